>>> src/rlrp_pkg.sv
// Shared types and constants for the rate limit request parser.
// Used by the front parser, the result queue, the back emitter and the checker.
package rlrp_pkg;

	typedef enum logic [3:0] {
		PH_VER,
		PH_ADDR,
		PH_PORT,
		PH_ULEN,
		PH_URL,
		PH_MAX,
		PH_TTL,
		PH_SKIP
	} phase_t;

	localparam logic [1:0] KIND_URL = 2'd0;
	localparam logic [1:0] KIND_REC = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [2:0] ERR_VERSION  = 3'd0;
	localparam logic [2:0] ERR_SHORT_V4 = 3'd1;
	localparam logic [2:0] ERR_SHORT_V6 = 3'd2;
	localparam logic [2:0] ERR_NO_PORT  = 3'd3;
	localparam logic [2:0] ERR_NO_ULEN  = 3'd4;
	localparam logic [2:0] ERR_URL_CUT  = 3'd5;
	localparam logic [2:0] ERR_NO_MAX   = 3'd6;
	localparam logic [2:0] ERR_NO_TTL   = 3'd7;

	localparam logic [7:0] VERSION_4 = 8'd4;
	localparam logic [7:0] VERSION_6 = 8'd6;
	localparam logic [8:0] ADDR4_BYTES = 9'd4;
	localparam logic [8:0] ADDR6_BYTES = 9'd16;
	localparam logic [8:0] PORT_BYTES  = 9'd2;
	localparam logic [8:0] TTL_BYTES   = 9'd4;

	localparam int QUEUE_DEPTH = 4;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 208;
	localparam int OUT_USER_W = 2;

	localparam int OFS_URL   = 0;
	localparam int OFS_IPV6  = 8;
	localparam int OFS_AHIGH = 9;
	localparam int OFS_ALOW  = 73;
	localparam int OFS_PORT  = 137;
	localparam int OFS_ULEN  = 153;
	localparam int OFS_LIMIT = 161;
	localparam int OFS_TTL   = 169;
	localparam int OFS_ERR   = 201;

	typedef struct packed {
		logic        has_url;
		logic [7:0]  url_char;
		logic        has_tail;
		logic        tail_rec;
		logic [2:0]  error_code;
		logic        is_ipv6;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [15:0] port_number;
		logic [7:0]  url_length;
		logic [7:0]  request_limit;
		logic [31:0] lifetime_ms;
	} entry_t;

endpackage

>>> src/rlrp_front.sv
// Front parser: accepts request bytes, tracks the record fields and classifies
// each byte into queue entries. Depends on rlrp_pkg.
module rlrp_front
	import rlrp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte [7:0]
	input  logic         s_tlast,
	input  logic         q_full,
	output logic         q_push,
	output entry_t       q_entry
);

	phase_t      phase_q, phase_d;
	logic [7:0]  cnt_q, cnt_d;
	logic        v6_q, v6_d;
	logic [63:0] ahigh_q, ahigh_d;
	logic [63:0] alow_q, alow_d;
	logic [15:0] port_q, port_d;
	logic [7:0]  ulen_q, ulen_d;
	logic [7:0]  limit_q, limit_d;
	logic [31:0] ttl_q, ttl_d;

	logic        accept;
	logic [8:0]  cnt_inc;
	logic        done;
	logic        err;
	logic        rec;
	logic        url;
	logic [2:0]  code;
	logic [31:0] ttl_shift;
	logic        good_ver;

	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign cnt_inc   = {1'b0, cnt_q} + 9'd1;
	assign ttl_shift = {ttl_q[23:0], s_tdata};
	assign good_ver  = (s_tdata == VERSION_4) || (s_tdata == VERSION_6);

	always_comb begin
		unique case (phase_q)
			PH_ADDR: done = cnt_inc >= (v6_q ? ADDR6_BYTES : ADDR4_BYTES);
			PH_PORT: done = cnt_inc >= PORT_BYTES;
			PH_URL:  done = cnt_inc >= {1'b0, ulen_q};
			PH_TTL:  done = cnt_inc >= TTL_BYTES;
			default: done = 1'b0;
		endcase
	end

	always_comb begin
		err  = 1'b0;
		rec  = 1'b0;
		url  = 1'b0;
		code = ERR_VERSION;
		unique case (phase_q)
			PH_VER: begin
				if (!good_ver) begin
					err = 1'b1;
				end else if (s_tlast) begin
					err  = 1'b1;
					code = (s_tdata == VERSION_6) ? ERR_SHORT_V6 : ERR_SHORT_V4;
				end
			end
			PH_ADDR: begin
				err  = s_tlast;
				code = done ? ERR_NO_PORT : (v6_q ? ERR_SHORT_V6 : ERR_SHORT_V4);
			end
			PH_PORT: begin
				err  = s_tlast;
				code = done ? ERR_NO_ULEN : ERR_NO_PORT;
			end
			PH_ULEN: begin
				err  = s_tlast;
				code = (s_tdata == 8'd0) ? ERR_NO_MAX : ERR_URL_CUT;
			end
			PH_URL: begin
				url  = 1'b1;
				err  = s_tlast;
				code = done ? ERR_NO_MAX : ERR_URL_CUT;
			end
			PH_MAX: begin
				err  = s_tlast;
				code = ERR_NO_TTL;
			end
			PH_TTL: begin
				rec  = done;
				err  = !done && s_tlast;
				code = ERR_NO_TTL;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		q_push                = accept && (url || err || rec);
		q_entry.has_url       = url;
		q_entry.url_char      = s_tdata;
		q_entry.has_tail      = err || rec;
		q_entry.tail_rec      = rec;
		q_entry.error_code    = code;
		q_entry.is_ipv6       = v6_q;
		q_entry.addr_high     = ahigh_q;
		q_entry.addr_low      = alow_q;
		q_entry.port_number   = port_q;
		q_entry.url_length    = ulen_q;
		q_entry.request_limit = limit_q;
		q_entry.lifetime_ms   = ttl_shift;
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		v6_d    = v6_q;
		ahigh_d = ahigh_q;
		alow_d  = alow_q;
		port_d  = port_q;
		ulen_d  = ulen_q;
		limit_d = limit_q;
		ttl_d   = ttl_q;
		unique case (phase_q)
			PH_VER: begin
				cnt_d   = '0;
				ahigh_d = '0;
				alow_d  = '0;
				port_d  = '0;
				ulen_d  = '0;
				limit_d = '0;
				ttl_d   = '0;
				v6_d    = s_tdata == VERSION_6;
				if (good_ver) begin
					phase_d = PH_ADDR;
				end
			end
			PH_ADDR: begin
				if (v6_q) begin
					ahigh_d = {ahigh_q[55:0], alow_q[63:56]};
					alow_d  = {alow_q[55:0], s_tdata};
				end else begin
					alow_d = {32'd0, alow_q[23:0], s_tdata};
				end
				cnt_d = cnt_inc[7:0];
				if (done) begin
					cnt_d   = '0;
					phase_d = PH_PORT;
				end
			end
			PH_PORT: begin
				port_d = {port_q[7:0], s_tdata};
				cnt_d  = cnt_inc[7:0];
				if (done) begin
					cnt_d   = '0;
					phase_d = PH_ULEN;
				end
			end
			PH_ULEN: begin
				ulen_d  = s_tdata;
				cnt_d   = '0;
				phase_d = (s_tdata == 8'd0) ? PH_MAX : PH_URL;
			end
			PH_URL: begin
				cnt_d = cnt_inc[7:0];
				if (done) begin
					cnt_d   = '0;
					phase_d = PH_MAX;
				end
			end
			PH_MAX: begin
				limit_d = s_tdata;
				cnt_d   = '0;
				phase_d = PH_TTL;
			end
			PH_TTL: begin
				ttl_d = ttl_shift;
				cnt_d = done ? 8'd0 : cnt_inc[7:0];
			end
			default: begin
				if (s_tlast) begin
					phase_d = PH_VER;
				end
			end
		endcase
		if (err || rec) begin
			phase_d = s_tlast ? PH_VER : PH_SKIP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VER;
			cnt_q   <= '0;
			v6_q    <= 1'b0;
			ahigh_q <= '0;
			alow_q  <= '0;
			port_q  <= '0;
			ulen_q  <= '0;
			limit_q <= '0;
			ttl_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			v6_q    <= v6_d;
			ahigh_q <= ahigh_d;
			alow_q  <= alow_d;
			port_q  <= port_d;
			ulen_q  <= ulen_d;
			limit_q <= limit_d;
			ttl_q   <= ttl_d;
		end
	end

endmodule

>>> src/rlrp_fifo.sv
// Short queue of classified entries between the front parser and the back
// emitter. Depends on rlrp_pkg for the entry type.
module rlrp_fifo
	import rlrp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> src/rlrp_back.sv
// Back emitter: drains queue entries and drives the result stream from an
// output register, one result per cycle unless stalled. Depends on rlrp_pkg.
module rlrp_back
	import rlrp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  entry_t                q_head,
	input  logic                  q_empty,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser
);

	logic                  valid_q;
	logic                  sub_q;
	logic                  sub_d;
	logic [OUT_DATA_W-1:0] data_q;
	logic [OUT_DATA_W-1:0] data_d;
	logic [OUT_USER_W-1:0] kind_q;
	logic [OUT_USER_W-1:0] kind_d;
	logic                  load;
	logic                  send_url;

	assign load     = !q_empty && (!valid_q || m_tready);
	assign send_url = q_head.has_url && !sub_q;
	assign q_pop    = load && !(send_url && q_head.has_tail);
	assign sub_d    = load ? (send_url && q_head.has_tail) : sub_q;

	always_comb begin
		data_d = '0;
		kind_d = KIND_URL;
		if (send_url) begin
			data_d[OFS_URL +: 8] = q_head.url_char;
		end else if (q_head.tail_rec) begin
			kind_d                   = KIND_REC;
			data_d[OFS_IPV6]         = q_head.is_ipv6;
			data_d[OFS_AHIGH +: 64]  = q_head.addr_high;
			data_d[OFS_ALOW +: 64]   = q_head.addr_low;
			data_d[OFS_PORT +: 16]   = q_head.port_number;
			data_d[OFS_ULEN +: 8]    = q_head.url_length;
			data_d[OFS_LIMIT +: 8]   = q_head.request_limit;
			data_d[OFS_TTL +: 32]    = q_head.lifetime_ms;
		end else begin
			kind_d                 = KIND_ERR;
			data_d[OFS_ERR +: 3]   = q_head.error_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			sub_q <= sub_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_d;
			kind_q <= kind_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;

endmodule

>>> src/rate_limit_request_parser_core.sv
// Top level of the rate limit request parser: front parser, entry queue and
// back emitter. Depends on rlrp_pkg, rlrp_front, rlrp_fifo and rlrp_back.
//
// Usage: request buffers arrive one byte per transaction on the s_ channel,
// s_tlast marking the last byte of a buffer. Results leave on the m_ channel:
// m_tuser gives the kind (URL byte, completed record, parse error) and
// m_tdata the fields of that kind, with every other field zero.
// Each accepted byte is classified in the cycle it is taken and, if it yields
// results, is written to a small queue (FIFO_DEPTH entries). Its results pass
// through the queue and then the output register before they reach m_tvalid.
// Throughput is one byte per cycle while the queue is not full. A URL byte that
// also ends the buffer yields two results, sent one after the other.
// When the receiver holds m_tready low the result stays in the output
// register and the queue fills; s_tready falls only when the queue is full.
// Reset clears the parser state to expect a version byte and empties the
// queue and the output register.
module rate_limit_request_parser_core
	import rlrp_pkg::*;
#(
	parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // data_byte [7:0]
	input  logic                  s_tlast,   // end_of_buffer
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// url_char [7:0], is_ipv6 [8], addr_high [72:9], addr_low [136:73],
	// port_number [152:137], url_length [160:153], request_limit [168:161],
	// lifetime_ms [200:169], error_code [203:201], zero [207:204]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser    // kind [1:0]
);

	entry_t push_entry;
	entry_t head_entry;
	logic   push;
	logic   full;
	logic   pop;
	logic   empty;

	rlrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (full),
		.q_push   (push),
		.q_entry  (push_entry)
	);

	rlrp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (full),
		.pop       (pop),
		.pop_data  (head_entry),
		.empty     (empty)
	);

	rlrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_head   (head_entry),
		.q_empty  (empty),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> src/rlrp_checker.sv
// Port-level checker for the rate limit request parser and its bind to the
// top level. Depends on rlrp_pkg and rate_limit_request_parser_core.
module rlrp_checker
	import rlrp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result valid dropped while stalled.");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("Result payload changed while stalled.");

	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_URL || m_tuser == KIND_REC || m_tuser == KIND_ERR))
		else $error("Result kind out of range.");

	a_url_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_URL |-> m_tdata[OUT_DATA_W-1:8] == '0)
		else $error("URL result carries record or error fields.");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ERR |-> m_tdata[OFS_ERR-1:0] == '0)
		else $error("Error result carries record or URL fields.");

endmodule

bind rate_limit_request_parser_core rlrp_checker u_rlrp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> verif/request_parse_checker.sv
`timescale 1ns / 1ps
// Checker for the rate limit request parser: watches the byte input and the result output,
// predicts the results of each accepted byte and compares them in order, field by field.
// Depends on rlrp_pkg for the phase, kind, error code and field offset constants.
module request_parse_checker
	import rlrp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // data_byte [7:0]
	input  logic                  s_tlast,   // end_of_buffer
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// url_char [7:0], is_ipv6 [8], addr_high [72:9], addr_low [136:73],
	// port_number [152:137], url_length [160:153], request_limit [168:161],
	// lifetime_ms [200:169], error_code [203:201], zero [207:204]
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [OUT_USER_W-1:0] m_tuser,   // kind [1:0]
	output int                    fail_count,
	output int                    results_due
);

	localparam int REPORT_LIMIT = 10;
	localparam int PAD_OFS = OFS_ERR + 3;
	localparam int PAD_W = OUT_DATA_W - PAD_OFS;

	typedef struct {
		logic [OUT_USER_W-1:0] kind;
		logic [OUT_DATA_W-1:0] data;
	} parse_result_t;

	parse_result_t due_results[$];
	int results_seen;

	phase_t      rx_phase;
	logic [8:0]  rx_count;
	logic        rx_v6;
	logic [63:0] acc_hi;
	logic [63:0] acc_lo;
	logic [15:0] acc_port;
	logic [7:0]  acc_ulen;
	logic [7:0]  acc_limit;
	logic [31:0] acc_ttl;

	initial begin
		fail_count = 0;
		results_due = 0;
		results_seen = 0;
	end

	task automatic push_url(input logic [7:0] b);
		parse_result_t r;
		r.kind = KIND_URL;
		r.data = '0;
		r.data[OFS_URL +: 8] = b;
		due_results.insert(due_results.size(), r);
	endtask

	task automatic push_error(input logic [2:0] code, input logic last);
		parse_result_t r;
		r.kind = KIND_ERR;
		r.data = '0;
		r.data[OFS_ERR +: 3] = code;
		due_results.insert(due_results.size(), r);
		rx_phase = last ? PH_VER : PH_SKIP;
	endtask

	task automatic push_record(input logic last);
		parse_result_t r;
		r.kind = KIND_REC;
		r.data = '0;
		r.data[OFS_IPV6] = rx_v6;
		r.data[OFS_AHIGH +: 64] = acc_hi;
		r.data[OFS_ALOW +: 64] = acc_lo;
		r.data[OFS_PORT +: 16] = acc_port;
		r.data[OFS_ULEN +: 8] = acc_ulen;
		r.data[OFS_LIMIT +: 8] = acc_limit;
		r.data[OFS_TTL +: 32] = acc_ttl;
		due_results.insert(due_results.size(), r);
		rx_phase = last ? PH_VER : PH_SKIP;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		case (rx_phase)
			PH_VER: begin
				rx_count = '0;
				acc_hi = '0;
				acc_lo = '0;
				acc_port = '0;
				acc_ulen = '0;
				acc_limit = '0;
				acc_ttl = '0;
				if (b == VERSION_4 || b == VERSION_6) begin
					rx_v6 = (b == VERSION_6);
					rx_phase = PH_ADDR;
					if (last) push_error(rx_v6 ? ERR_SHORT_V6 : ERR_SHORT_V4, last);
				end else begin
					rx_v6 = 1'b0;
					push_error(ERR_VERSION, last);
				end
			end
			PH_ADDR: begin
				if (rx_v6) {acc_hi, acc_lo} = {acc_hi[55:0], acc_lo, b};
				else acc_lo = {32'd0, acc_lo[23:0], b};
				rx_count = rx_count + 9'd1;
				if (rx_count >= (rx_v6 ? ADDR6_BYTES : ADDR4_BYTES)) begin
					rx_count = '0;
					rx_phase = PH_PORT;
					if (last) push_error(ERR_NO_PORT, last);
				end else if (last) begin
					push_error(rx_v6 ? ERR_SHORT_V6 : ERR_SHORT_V4, last);
				end
			end
			PH_PORT: begin
				acc_port = {acc_port[7:0], b};
				rx_count = rx_count + 9'd1;
				if (rx_count >= PORT_BYTES) begin
					rx_count = '0;
					rx_phase = PH_ULEN;
					if (last) push_error(ERR_NO_ULEN, last);
				end else if (last) begin
					push_error(ERR_NO_PORT, last);
				end
			end
			PH_ULEN: begin
				acc_ulen = b;
				rx_count = '0;
				if (b == 8'd0) begin
					rx_phase = PH_MAX;
					if (last) push_error(ERR_NO_MAX, last);
				end else begin
					rx_phase = PH_URL;
					if (last) push_error(ERR_URL_CUT, last);
				end
			end
			PH_URL: begin
				push_url(b);
				rx_count = rx_count + 9'd1;
				if (rx_count >= {1'b0, acc_ulen}) begin
					rx_count = '0;
					rx_phase = PH_MAX;
					if (last) push_error(ERR_NO_MAX, last);
				end else if (last) begin
					push_error(ERR_URL_CUT, last);
				end
			end
			PH_MAX: begin
				acc_limit = b;
				rx_count = '0;
				rx_phase = PH_TTL;
				if (last) push_error(ERR_NO_TTL, last);
			end
			PH_TTL: begin
				acc_ttl = {acc_ttl[23:0], b};
				rx_count = rx_count + 9'd1;
				if (rx_count >= TTL_BYTES) begin
					rx_count = '0;
					push_record(last);
				end else if (last) begin
					push_error(ERR_NO_TTL, last);
				end
			end
			default: begin
				if (last) rx_phase = PH_VER;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("Result %0d: %s expected %h, got %h", results_seen, name, want, got);
		end
	endtask

	task automatic check_result();
		parse_result_t r;
		if (due_results.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("Result %0d: none expected, got kind %0d data %h",
					results_seen, m_tuser, m_tdata);
		end else begin
			r = due_results.pop_front();
			check_field("kind", 64'(r.kind), 64'(m_tuser));
			check_field("url_char", 64'(r.data[OFS_URL +: 8]), 64'(m_tdata[OFS_URL +: 8]));
			check_field("is_ipv6", 64'(r.data[OFS_IPV6]), 64'(m_tdata[OFS_IPV6]));
			check_field("addr_high", r.data[OFS_AHIGH +: 64], m_tdata[OFS_AHIGH +: 64]);
			check_field("addr_low", r.data[OFS_ALOW +: 64], m_tdata[OFS_ALOW +: 64]);
			check_field("port_number", 64'(r.data[OFS_PORT +: 16]),
				64'(m_tdata[OFS_PORT +: 16]));
			check_field("url_length", 64'(r.data[OFS_ULEN +: 8]), 64'(m_tdata[OFS_ULEN +: 8]));
			check_field("request_limit", 64'(r.data[OFS_LIMIT +: 8]),
				64'(m_tdata[OFS_LIMIT +: 8]));
			check_field("lifetime_ms", 64'(r.data[OFS_TTL +: 32]), 64'(m_tdata[OFS_TTL +: 32]));
			check_field("error_code", 64'(r.data[OFS_ERR +: 3]), 64'(m_tdata[OFS_ERR +: 3]));
			check_field("padding", 64'(r.data[PAD_OFS +: PAD_W]), 64'(m_tdata[PAD_OFS +: PAD_W]));
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase = PH_VER;
			rx_count = '0;
			rx_v6 = 1'b0;
			acc_hi = '0;
			acc_lo = '0;
			acc_port = '0;
			acc_ulen = '0;
			acc_limit = '0;
			acc_ttl = '0;
			due_results.delete();
			results_due = 0;
		end else begin
			if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) check_result();
			results_due = due_results.size();
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the rate limit request parser testbench: clock, reset, byte stimulus with
// random gaps, a stalling result sink, a watchdog and the final verdict.
// Depends on rlrp_pkg, rate_limit_request_parser_core and request_parse_checker.
module tb_top;
	import rlrp_pkg::*;

	localparam int ITEM_TARGET = 1750;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	int fail_count;
	int results_due;
	int items_sent = 0;
	int idle_cycles = 0;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;
	logic [7:0] frame_q[$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rate_limit_request_parser_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	request_parse_checker parse_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	// Now and then a side switches between random waits and back-to-back transactions.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 31) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic last);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Sends the buffer up to and including the byte at stop, which is marked last.
	// Bytes past body are trailing bytes that the parser skips.
	task automatic send_frame(input int stop, input int body);
		for (int i = 0; i <= stop; i++) send_byte(frame_q[i], i == stop);
		items_sent += (stop < body) ? stop + 1 : body;
	endtask

	task automatic build_record(input logic v6, input int ulen);
		frame_q = {};
		frame_q.insert(frame_q.size(), v6 ? VERSION_6 : VERSION_4);
		repeat (v6 ? ADDR6_BYTES : ADDR4_BYTES) frame_q.insert(frame_q.size(), pick_byte());
		repeat (PORT_BYTES) frame_q.insert(frame_q.size(), pick_byte());
		frame_q.insert(frame_q.size(), 8'(ulen));
		repeat (ulen) frame_q.insert(frame_q.size(), pick_byte());
		frame_q.insert(frame_q.size(), pick_byte());
		repeat (TTL_BYTES) frame_q.insert(frame_q.size(), pick_byte());
	endtask

	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = draw_wait(take_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int stop;
		int body;
		int ulen;
		logic v6;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		frame_q = {8'h00};
		send_frame(0, 1);
		frame_q = {8'hFF, VERSION_6, VERSION_4};
		send_frame(2, 1);
		frame_q = {VERSION_4};
		send_frame(0, 1);
		frame_q = {VERSION_6};
		send_frame(0, 1);
		frame_q = {VERSION_4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame(12, 13);
		frame_q = {VERSION_4, 8'h00, 8'h00, 8'h00, 8'h00};
		send_frame(4, 5);

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 99) < 85) begin
				v6 = 1'($urandom_range(0, 1));
				ulen = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 255)
					: $urandom_range(0, 8);
				build_record(v6, ulen);
				body = frame_q.size();
				if ($urandom_range(0, 1) == 1) begin
					repeat ($urandom_range(0, 3)) frame_q.insert(frame_q.size(), pick_byte());
					stop = frame_q.size() - 1;
				end else begin
					stop = $urandom_range(0, body - 1);
				end
			end else begin
				frame_q = {};
				repeat ($urandom_range(1, 6)) frame_q.insert(frame_q.size(), pick_byte());
				body = frame_q.size();
				stop = body - 1;
			end
			send_frame(stop, body);
		end
		s_tvalid <= 1'b0;

		@(negedge clk);
		wait (results_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && results_due == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
src/rlrp_pkg.sv
src/rlrp_front.sv
src/rlrp_fifo.sv
src/rlrp_back.sv
src/rate_limit_request_parser_core.sv
src/rlrp_checker.sv
verif/request_parse_checker.sv
verif/tb_top.sv
